>>> hdl/stgf_pkg.sv
// ----------------------------------------------------------------------------
// stgf_pkg: shared constants for the sine tone generator with fade
// Default parameter values, register indexes, tone limits and the
// coefficients of the quarter-wave sine polynomial.
// ----------------------------------------------------------------------------
package stgf_pkg;

  // parameter defaults
  localparam int SAMPLE_RATE_DEF     = 48000;
  localparam int FADE_FRAMES_DEF     = 200;
  localparam int TAIL_FRAMES_DEF     = 256;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // tone limits and reset values
  localparam int AMPLITUDE  = 6000;
  localparam int FREQ_MIN   = 100;
  localparam int FREQ_MAX   = 8000;
  localparam int FREQ_RESET = 1000;
  localparam int DUR_RESET  = 100;
  localparam int MS_PER_S   = 1000;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQUENCY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_MS    = 1'b1;

  // sample path widths
  localparam int SAMPLE_W   = 14;
  localparam int MAG_W      = 13;  // magnitude never exceeds AMPLITUDE
  localparam int SINE_W     = 15;  // Q15 magnitude, capped at 32767
  localparam int POLY_W     = 16;
  localparam int AMP_PROD_W = 28;  // AMPLITUDE * 32767 fits here
  localparam int Q15_SHIFT  = 15;

  // quarter-wave polynomial coefficients (Q15 scaled)
  localparam logic [POLY_W-1:0] COEF_C1  = 16'd51472;
  localparam logic [POLY_W-1:0] COEF_C3  = 16'd21167;
  localparam logic [POLY_W-1:0] COEF_C5  = 16'd2611;
  localparam logic [POLY_W-1:0] COEF_C7  = 16'd153;
  localparam logic [POLY_W-1:0] HALF_PI  = 16'h8000;
  localparam logic [POLY_W-1:0] SINE_CAP = 16'd32767;

endpackage

>>> hdl/sine_tone_generator_fade_core.sv
// Tone frame: out_valid rises after the bit-serial phase-to-index divider, the polynomial
//   steps and the 13-step fade divider; a new transaction is taken only once the frame
//   has been loaded into the output register.
// Silent frame: no divider runs; the next transaction is taken once the frame is loaded.
// Idle ticks give no frame. A duration write holds in_ready low during the length divide.
// Reset (synchronous, rst_n low): idle, 1000 Hz, 100 ms, phase and counters at zero.
// ----------------------------------------------------------------------------
// sine_tone_generator_fade_core: DDS beep with linear fade and silent tail
// One stereo frame per non-idle tick: sine from a Q15 polynomial on a shared multiplier,
// scaled by the fade ratio through a bit-serial divider, then trailing silence.
// ----------------------------------------------------------------------------
module sine_tone_generator_fade_core #(
  parameter int SAMPLE_RATE     = stgf_pkg::SAMPLE_RATE_DEF,
  parameter int FADE_FRAMES     = stgf_pkg::FADE_FRAMES_DEF,
  parameter int TAIL_FRAMES     = stgf_pkg::TAIL_FRAMES_DEF,
  parameter int SINE_TABLE_BITS = stgf_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [stgf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stgf_pkg::CFG_W-1:0]           cfg_data,
  // ticks
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_start_req,
  // frames
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [stgf_pkg::SAMPLE_W-1:0] out_sample_left,
  output logic signed [stgf_pkg::SAMPLE_W-1:0] out_sample_right,
  output logic                                 out_tone_on,
  output logic                                 out_last
);

  localparam int     B        = SINE_TABLE_BITS;
  localparam int     PH_W     = $clog2(SAMPLE_RATE);
  localparam int     FREQ_W   = $clog2(stgf_pkg::FREQ_MAX + 1);
  localparam longint PROD_MAX = longint'(65535) * longint'(SAMPLE_RATE);
  localparam int     PROD_W   = $clog2(PROD_MAX + 1);
  localparam longint TOT_MAX  = PROD_MAX / stgf_pkg::MS_PER_S;
  localparam int     TOT_W    = $clog2(TOT_MAX + 1);
  localparam int     DREM_W   = $clog2(stgf_pkg::MS_PER_S);
  localparam int     PCNT_W   = $clog2(PROD_W + 1);
  localparam int     TOT_RST  = (SAMPLE_RATE * stgf_pkg::DUR_RESET) / stgf_pkg::MS_PER_S;
  localparam int     FADE_W   = $clog2(FADE_FRAMES + 1);
  localparam int     SIL_W    = (TAIL_FRAMES > 0) ? $clog2(TAIL_FRAMES + 1) : 1;
  localparam int     ICNT_W   = $clog2(B + 1);
  localparam int     MAG_W    = stgf_pkg::MAG_W;
  localparam int     DCNT_W   = $clog2(MAG_W + 1);
  localparam int     FPROD_W  = stgf_pkg::AMP_PROD_W + FADE_W;
  localparam int     X_W      = FPROD_W - stgf_pkg::Q15_SHIFT;
  localparam int     POLY_W   = stgf_pkg::POLY_W;
  localparam int     SAMPLE_W = stgf_pkg::SAMPLE_W;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_TONE = 3'b010,
    MODE_TAIL = 3'b100
  } mode_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_IDX  = 7'b0000010,
    S_POLY = 7'b0000100,
    S_AMP  = 7'b0001000,
    S_FADE = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } seq_state_t;

  typedef enum logic [4:0] {
    PS_SQ  = 5'b00001,
    PS_P1  = 5'b00010,
    PS_P2  = 5'b00100,
    PS_P3  = 5'b01000,
    PS_OUT = 5'b10000
  } poly_step_t;

  localparam mode_t TAIL_ENTRY = (TAIL_FRAMES > 0) ? MODE_TAIL : MODE_IDLE;

  // control and beep state
  seq_state_t         state_r;
  poly_step_t         pstep_r;
  mode_t              mode_r;
  logic [TOT_W-1:0]   fi_r;
  logic [PH_W-1:0]    ph_r;
  logic [SIL_W-1:0]   sil_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [TOT_W-1:0]   total_r;
  logic               tot_busy_r;
  logic [PCNT_W-1:0]  tc_r;
  logic [ICNT_W-1:0]  icnt_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic               out_valid_r;

  // datapath
  logic [PROD_W-1:0]                tp_r;
  logic [DREM_W-1:0]                tr_r;
  logic [TOT_W-1:0]                 tq_r;
  logic [PH_W-1:0]                  ir_r;
  logic [B-1:0]                     idx_r;
  logic [POLY_W-1:0]                t2_r;
  logic [POLY_W-1:0]                p_r;
  logic [stgf_pkg::AMP_PROD_W-1:0]  a_r;
  logic [FADE_W-1:0]                rem_eff_r;
  logic [X_W-1:0]                   nr_r;
  logic [X_W-1:0]                   dv_r;
  logic [MAG_W-1:0]                 mag_r;
  logic                             tone_r;
  logic                             last_r;
  logic signed [SAMPLE_W-1:0]       out_sample_r;
  logic                             out_tone_r;
  logic                             out_last_r;

  logic accept;
  logic out_load;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !tot_busy_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // --------------------------------------------------------------------------
  // per-tick decisions
  // --------------------------------------------------------------------------
  logic [TOT_W-1:0]  fi0;
  logic [PH_W-1:0]   ph0;
  mode_t             mode0;
  mode_t             mode1;
  logic              early_end;
  logic              fade_on;
  logic [TOT_W:0]    fi_inc;
  logic              fin_tone;
  logic [PH_W:0]     ph_sum;
  logic [PH_W-1:0]   ph_nxt;
  logic [SIL_W-1:0]  sil0;
  logic [SIL_W:0]    sil_inc;
  logic              fin_tail;
  logic [FADE_W-1:0] rem_eff_nxt;

  always_comb begin
    fi0       = in_start_req ? '0 : fi_r;
    ph0       = in_start_req ? '0 : ph_r;
    mode0     = in_start_req ? MODE_TONE : mode_r;
    early_end = (mode0 == MODE_TONE) && (fi0 >= total_r);
    mode1     = early_end ? TAIL_ENTRY : mode0;
    fade_on   = ({1'b0, total_r} > (TOT_W+1)'(FADE_FRAMES)) &&
                (({1'b0, fi0} + (TOT_W+1)'(FADE_FRAMES)) >= {1'b0, total_r});
    rem_eff_nxt = fade_on ? FADE_W'(total_r - fi0) : FADE_W'(FADE_FRAMES);
    fi_inc    = {1'b0, fi0} + (TOT_W+1)'(1);
    fin_tone  = fi_inc >= {1'b0, total_r};
    ph_sum    = (PH_W+1)'(ph0) + (PH_W+1)'(freq_r);
    ph_nxt    = (ph_sum >= (PH_W+1)'(SAMPLE_RATE)) ?
                PH_W'(ph_sum - (PH_W+1)'(SAMPLE_RATE)) : PH_W'(ph_sum);
    sil0      = early_end ? '0 : sil_r;
    sil_inc   = (SIL_W+1)'(sil0) + (SIL_W+1)'(1);
    fin_tail  = sil_inc >= (SIL_W+1)'(TAIL_FRAMES);
  end

  // --------------------------------------------------------------------------
  // serial units
  // --------------------------------------------------------------------------
  // tone length: duration * SAMPLE_RATE / 1000, one quotient bit a cycle
  logic [DREM_W:0]   trs;
  logic              tge;
  logic [TOT_W-1:0]  tq_nxt;
  logic [DREM_W-1:0] tr_nxt;
  always_comb begin
    trs    = {tr_r, tp_r[PROD_W-1]};
    tge    = trs >= (DREM_W+1)'(stgf_pkg::MS_PER_S);
    tr_nxt = tge ? DREM_W'(trs - (DREM_W+1)'(stgf_pkg::MS_PER_S)) : DREM_W'(trs);
    tq_nxt = {tq_r[TOT_W-2:0], tge};
  end

  // phase to table index: (phase << B) / SAMPLE_RATE, restoring, one bit a cycle
  logic [PH_W:0] irs;
  logic          ige;
  always_comb begin
    irs = {ir_r, 1'b0};
    ige = irs >= (PH_W+1)'(SAMPLE_RATE);
  end

  // quarter-wave argument from the index
  logic [1:0]        quad;
  logic [POLY_W-1:0] t_even;
  logic [POLY_W-1:0] t_c;
  always_comb begin
    quad   = idx_r[B-1:B-2];
    t_even = POLY_W'(idx_r[B-3:0]) << (17 - B);
    t_c    = quad[0] ? (stgf_pkg::HALF_PI - t_even) : t_even;
  end

  // shared polynomial multiplier
  logic [POLY_W-1:0]   mul_a;
  logic [POLY_W-1:0]   mul_b;
  logic [2*POLY_W-1:0] mul_p;
  logic [POLY_W:0]     mul_q;
  always_comb begin
    case (pstep_r)
      PS_SQ: begin
        mul_a = t_c;
        mul_b = t_c;
      end
      PS_P1: begin
        mul_a = t2_r;
        mul_b = stgf_pkg::COEF_C7;
      end
      PS_P2, PS_P3: begin
        mul_a = t2_r;
        mul_b = p_r;
      end
      PS_OUT: begin
        mul_a = t_c;
        mul_b = p_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = (2*POLY_W)'(mul_a) * (2*POLY_W)'(mul_b);
    mul_q = mul_p[2*POLY_W-1:stgf_pkg::Q15_SHIFT];
  end

  logic [FPROD_W-1:0] fprod;
  logic               dge;
  assign fprod = FPROD_W'(a_r) * FPROD_W'(rem_eff_r);
  assign dge   = nr_r >= dv_r;

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pstep_r     <= PS_SQ;
      mode_r      <= MODE_IDLE;
      fi_r        <= '0;
      ph_r        <= '0;
      sil_r       <= '0;
      freq_r      <= FREQ_W'(stgf_pkg::FREQ_RESET);
      total_r     <= TOT_W'(TOT_RST);
      tot_busy_r  <= 1'b0;
      tc_r        <= '0;
      icnt_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          stgf_pkg::REG_TONE_FREQUENCY: begin
            if (cfg_data < stgf_pkg::CFG_W'(stgf_pkg::FREQ_MIN)) begin
              freq_r <= FREQ_W'(stgf_pkg::FREQ_MIN);
            end else if (cfg_data > stgf_pkg::CFG_W'(stgf_pkg::FREQ_MAX)) begin
              freq_r <= FREQ_W'(stgf_pkg::FREQ_MAX);
            end else begin
              freq_r <= FREQ_W'(cfg_data);
            end
          end
          stgf_pkg::REG_DURATION_MS: begin
            tot_busy_r <= 1'b1;
            tc_r       <= PCNT_W'(PROD_W);
          end
          default: ;
        endcase
      end

      // tone length divider
      if (tot_busy_r && !(cfg_we && cfg_index == stgf_pkg::REG_DURATION_MS)) begin
        tc_r <= tc_r - PCNT_W'(1);
        if (tc_r == PCNT_W'(1)) begin
          total_r    <= tq_nxt;
          tot_busy_r <= 1'b0;
        end
      end

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (mode1)
              MODE_TONE: begin
                fi_r   <= TOT_W'(fi_inc);
                ph_r   <= ph_nxt;
                icnt_r <= ICNT_W'(B);
                if (fin_tone) begin
                  mode_r <= TAIL_ENTRY;
                  sil_r  <= '0;
                end else begin
                  mode_r <= MODE_TONE;
                end
                state_r <= S_IDX;
              end
              MODE_TAIL: begin
                fi_r    <= fi0;
                ph_r    <= ph0;
                sil_r   <= SIL_W'(sil_inc);
                mode_r  <= fin_tail ? MODE_IDLE : MODE_TAIL;
                state_r <= S_DONE;
              end
              default: begin
                // idle tick: no frame
                fi_r   <= fi0;
                ph_r   <= ph0;
                mode_r <= mode1;
              end
            endcase
          end
        end
        S_IDX: begin
          icnt_r <= icnt_r - ICNT_W'(1);
          if (icnt_r == ICNT_W'(1)) begin
            pstep_r <= PS_SQ;
            state_r <= S_POLY;
          end
        end
        S_POLY: begin
          case (pstep_r)
            PS_SQ:   pstep_r <= PS_P1;
            PS_P1:   pstep_r <= PS_P2;
            PS_P2:   pstep_r <= PS_P3;
            PS_P3:   pstep_r <= PS_OUT;
            PS_OUT:  state_r <= S_AMP;
            default: pstep_r <= PS_SQ;
          endcase
        end
        S_AMP: begin
          state_r <= S_FADE;
        end
        S_FADE: begin
          dcnt_r  <= DCNT_W'(MAG_W);
          state_r <= S_DIV;
        end
        S_DIV: begin
          dcnt_r <= dcnt_r - DCNT_W'(1);
          if (dcnt_r == DCNT_W'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cfg_we && cfg_index == stgf_pkg::REG_DURATION_MS) begin
      tp_r <= PROD_W'(cfg_data) * PROD_W'(SAMPLE_RATE);
      tr_r <= '0;
      tq_r <= '0;
    end else if (tot_busy_r) begin
      tp_r <= tp_r << 1;
      tr_r <= tr_nxt;
      tq_r <= tq_nxt;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ir_r      <= ph0;
          rem_eff_r <= rem_eff_nxt;
          if (mode1 == MODE_TONE) begin
            tone_r <= 1'b1;
            last_r <= fin_tone && (TAIL_FRAMES == 0);
          end else begin
            // silent frame
            tone_r <= 1'b0;
            last_r <= fin_tail;
            mag_r  <= '0;
          end
        end
      end
      S_IDX: begin
        ir_r  <= ige ? PH_W'(irs - (PH_W+1)'(SAMPLE_RATE)) : PH_W'(irs);
        idx_r <= {idx_r[B-2:0], ige};
      end
      S_POLY: begin
        case (pstep_r)
          PS_SQ:  t2_r <= mul_q[POLY_W-1:0];
          PS_P1:  p_r  <= stgf_pkg::COEF_C5 - mul_q[POLY_W-1:0];
          PS_P2:  p_r  <= stgf_pkg::COEF_C3 - mul_q[POLY_W-1:0];
          PS_P3:  p_r  <= stgf_pkg::COEF_C1 - mul_q[POLY_W-1:0];
          PS_OUT: p_r  <= (mul_q > (POLY_W+1)'(stgf_pkg::SINE_CAP)) ?
                          stgf_pkg::SINE_CAP : mul_q[POLY_W-1:0];
          default: ;
        endcase
      end
      S_AMP: begin
        a_r <= stgf_pkg::AMP_PROD_W'(p_r[stgf_pkg::SINE_W-1:0]) *
               stgf_pkg::AMP_PROD_W'(stgf_pkg::AMPLITUDE);
      end
      S_FADE: begin
        // fade ratio applies to every tone frame: outside the fade it is 1
        nr_r <= fprod[FPROD_W-1:stgf_pkg::Q15_SHIFT];
        dv_r <= X_W'(FADE_FRAMES) << (MAG_W - 1);
      end
      S_DIV: begin
        if (dge) begin
          nr_r <= nr_r - dv_r;
        end
        dv_r  <= dv_r >> 1;
        mag_r <= {mag_r[MAG_W-2:0], dge};
      end
      default: ;
    endcase

    if (out_load) begin
      // negative half-wave: negate the magnitude
      out_sample_r <= idx_r[B-1] ? -$signed(SAMPLE_W'(mag_r)) : $signed(SAMPLE_W'(mag_r));
      out_tone_r   <= tone_r;
      out_last_r   <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_left  = out_sample_r;
  assign out_sample_right = out_sample_r;
  assign out_tone_on      = out_tone_r;
  assign out_last         = out_last_r;

endmodule
